// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds across reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tspf_pkg.sv =====
// Package: constants, register indexes and queue entry type of the PID filter
`default_nettype none

package tspf_pkg;

  localparam int FILTER_SLOTS_DEF = 4;
  localparam int PID_REGS         = 4;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 13;
  localparam int PID_W            = 13;
  localparam int PID_HIGH_W       = 5;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [7:0] SYNC_MARK   = 8'h47;
  localparam logic [7:0] MIN_LENGTH  = 8'd3;
  localparam logic [7:0] MAX_LENGTH  = 8'd204;
  localparam logic [7:0] RST_LENGTH  = 8'd188;

  localparam logic [CFG_INDEX_W-1:0] REG_PACKET_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_COUNT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PID_BASE      = 3'd2;

  typedef struct packed {
    logic       burst;
    logic       last;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

`default_nettype wire

// ===== src/tspf_front.sv =====
// Front end: byte position counter, header hold, sync and PID classification
`default_nettype none

module tspf_front #(
  parameter int FILTER_SLOTS = tspf_pkg::FILTER_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             cfg_valid,
  input  wire logic [tspf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tspf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             q_full,
  output logic                                  push,
  output tspf_pkg::job_t                        push_job
);

  localparam int STORED = (FILTER_SLOTS < tspf_pkg::PID_REGS) ? FILTER_SLOTS
                                                              : tspf_pkg::PID_REGS;

  logic [7:0]                   packet_length;
  logic [2:0]                   filter_count;
  logic [tspf_pkg::PID_W-1:0]   pid_regs [STORED];
  logic [7:0]                   byte_position;
  logic [7:0]                   held0;
  logic [7:0]                   held1;
  logic                         passing;

  logic [7:0]                   len_eff;
  logic [2:0]                   active;
  logic [tspf_pkg::PID_W-1:0]   pid;
  logic                         match;
  logic                         last;
  logic                         accept;
  logic                         pass_now;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (packet_length < tspf_pkg::MIN_LENGTH) begin
      len_eff = tspf_pkg::MIN_LENGTH;
    end else if (packet_length > tspf_pkg::MAX_LENGTH) begin
      len_eff = tspf_pkg::MAX_LENGTH;
    end else begin
      len_eff = packet_length;
    end
  end

  assign active = (filter_count > 3'(STORED)) ? 3'(STORED) : filter_count;
  assign pid    = {held1[tspf_pkg::PID_HIGH_W-1:0], data_byte};
  assign last   = byte_position >= (len_eff - 8'd1);

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < STORED; i++) begin
      if ((3'(i) < active) && (pid_regs[i] == pid)) begin
        match = 1'b1;
      end
    end
  end

  assign pass_now = (held0 == tspf_pkg::SYNC_MARK) && match;

  always_comb begin
    push_job.burst = 1'b0;
    push_job.last  = last;
    push_job.b0    = held0;
    push_job.b1    = held1;
    push_job.b2    = data_byte;
    push           = 1'b0;
    if (accept) begin
      if (byte_position == 8'd2) begin
        push_job.burst = 1'b1;
        push           = pass_now;
      end else if (byte_position > 8'd2) begin
        push           = passing;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_length <= tspf_pkg::RST_LENGTH;
      filter_count  <= 3'd0;
      for (int i = 0; i < STORED; i++) begin
        pid_regs[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == tspf_pkg::REG_PACKET_LENGTH) begin
        packet_length <= cfg_data[7:0];
      end
      if (cfg_index == tspf_pkg::REG_FILTER_COUNT) begin
        filter_count <= cfg_data[2:0];
      end
      for (int i = 0; i < STORED; i++) begin
        if (cfg_index == (tspf_pkg::REG_PID_BASE + tspf_pkg::CFG_INDEX_W'(i))) begin
          pid_regs[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
      passing       <= 1'b0;
      held0         <= 8'd0;
      held1         <= 8'd0;
    end else if (accept) begin
      if (byte_position == 8'd0) begin
        held0   <= data_byte;
        passing <= 1'b0;
      end else if (byte_position == 8'd1) begin
        held1 <= data_byte;
      end else if (byte_position == 8'd2) begin
        passing <= pass_now && !last;
      end else if (last) begin
        passing <= 1'b0;
      end
      if (last) begin
        byte_position <= 8'd0;
      end else begin
        byte_position <= byte_position + 8'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tspf_queue.sv =====
// Short job queue between the classifier and the result sequencer
`default_nettype none

module tspf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tspf_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output tspf_pkg::head_t     head
);

  localparam int PTR_W = $clog2(tspf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tspf_pkg::QUEUE_DEPTH + 1);

  tspf_pkg::job_t     entries [tspf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = count == CNT_W'(tspf_pkg::QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tspf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tspf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tspf_back.sv =====
// Back end: expands queued jobs into result bytes through an output register
`default_nettype none

module tspf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tspf_pkg::head_t head,
  output logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 packet_end,
  output logic                 run_last,
  output logic                 out_valid,
  input  wire logic            out_stall
);

  logic [1:0] sub;
  logic       load;
  logic       final_sub;
  logic [7:0] cand_byte;

  assign load = !out_valid || !out_stall;

  always_comb begin
    if (head.job.burst) begin
      final_sub = sub == 2'd2;
      case (sub)
        2'd0:    cand_byte = head.job.b0;
        2'd1:    cand_byte = head.job.b1;
        default: cand_byte = head.job.b2;
      endcase
    end else begin
      final_sub = 1'b1;
      cand_byte = head.job.b2;
    end
  end

  assign pop = load && head.valid && final_sub;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= cand_byte;
      packet_end <= final_sub && head.job.last;
      run_last   <= final_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 2'd0;
    end else if (load) begin
      out_valid <= head.valid;
      if (head.valid) begin
        sub <= final_sub ? 2'd0 : sub + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ts_pid_packet_filter.sv =====
// Transport stream PID filter: one byte in per cycle when not stalled, bytes of
// matching packets out one per cycle when not stalled, via the job queue and
// the output register. Byte 2 of a passed packet releases three results, held
// in the four-entry job queue while the next packet's two header bytes give none,
// so an unstalled stream of packets of length 3 or more flows at one byte per
// cycle. in_stall rises only when the queue is full, i.e. when the output side
// has stalled. Config writes are always taken (cfg_ready is tied high).
`default_nettype none

module ts_pid_packet_filter #(
  parameter int FILTER_SLOTS = tspf_pkg::FILTER_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  output logic [7:0]                            out_byte,
  output logic                                  packet_end,
  output logic                                  run_last,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tspf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tspf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic            q_full;
  logic            push;
  logic            pop;
  tspf_pkg::job_t  push_job;
  tspf_pkg::head_t head;

  assign cfg_ready = 1'b1;

  tspf_front #(
    .FILTER_SLOTS (FILTER_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  tspf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  tspf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .run_last   (run_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire

// ===== src/tspf_checker.sv =====
// Port-level checker for the PID filter and its bind to the top level
`default_nettype none
`include "assert_macros.svh"

module tspf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic [7:0] out_byte,
  input wire logic       packet_end,
  input wire logic       run_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       cfg_ready
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(out_byte), "stalled result changed")
  `ASSERT_CLK(a_end_is_last, clk, rst, out_valid && packet_end |-> run_last, "packet end not last of its transaction")
  `ASSERT_CLK_NR(a_reset_quiet, clk, rst |=> !out_valid, "result shown right after reset")
  `ASSERT_CLK(a_cfg_ready, clk, rst, cfg_ready, "configuration write refused")

endmodule

bind ts_pid_packet_filter tspf_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_byte   (out_byte),
  .packet_end (packet_end),
  .run_last   (run_last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
